// ===== sv/wli_pkg.sv =====
// ----------------------------------------------------------------------------
// wli_pkg
// Types and constants shared by the waypoint linear interpolator
// ----------------------------------------------------------------------------
package wli_pkg;

  localparam int MAX_STEPS = 64;

  localparam int COORD_W = 32;
  localparam int HEAD_W  = 16;
  localparam int PPM_W   = 10;
  localparam int DATA_W  = 2 * COORD_W + HEAD_W;

  localparam logic [PPM_W-1:0] PPM_RESET = 10'd20;

  // q16.16 fraction bits dropped from the length product
  localparam int FRAC_W = 16;

  // operand bits of the square step, unsaturated deltas stay below 2^31
  localparam int SQ_OP_W  = COORD_W - 1;
  localparam int SQ_ACC_W = 2 * SQ_OP_W + 1;

  // root digits, two radicand bits per digit
  localparam int ROOT_W   = COORD_W;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int RREM_W   = ROOT_W + 2;

  localparam int MUL_W    = ROOT_W + PPM_W;
  localparam int TOP_W    = MUL_W - FRAC_W;

  localparam int N_W      = $clog2(MAX_STEPS + 1);
  localparam int J_W      = $clog2(MAX_STEPS - 1);
  localparam int IT_W     = 5;

  localparam logic [IT_W-1:0] SQ_LAST   = IT_W'(SQ_OP_W - 1);
  localparam logic [IT_W-1:0] ROOT_LAST = IT_W'(ROOT_W - 1);
  localparam logic [IT_W-1:0] MUL_LAST  = IT_W'(PPM_W - 1);
  localparam logic [IT_W-1:0] DIV_LAST  = IT_W'(COORD_W - 1);

  localparam logic [N_W-1:0] N_MAX  = N_W'(MAX_STEPS);
  localparam logic [N_W-1:0] N_MIN  = N_W'(3);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQR,
    S_ROOT,
    S_MUL,
    S_DIV,
    S_HEAD,
    S_STEP,
    S_END
  } state_t;

endpackage

// ===== sv/waypoint_linear_interpolator.sv =====
// ----------------------------------------------------------------------------
// waypoint_linear_interpolator
// Fills each segment between successive waypoints with evenly spaced points
//
//   channel  direction  tdata                        tlast        tuser
//   in_      slave      x_pos, y_pos, heading        end_of_path  -
//   out_     master     x_out, y_out, heading_out    run_last     path_end
//   cfg_     write      points_per_meter             -            -
//
// an item with no held point is stored; with tlast an end-of-path result follows
// a segment runs square, root, scale and divide, then gives one result per cycle
//   while out_tready allows; a very long segment skips square, root and scale,
//   a short one skips the divide and zero points_per_meter skips all four
// the square, root, scale and divide units are bit-serial
// out_tready low holds the result register and the block waits on it
// reset clears the held point and sets points_per_meter to 20
// ----------------------------------------------------------------------------
module waypoint_linear_interpolator (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_tvalid,
  output logic                        in_tready,
  // x_pos [31:0], y_pos [63:32], heading [79:64]
  input  logic [wli_pkg::DATA_W-1:0]  in_tdata,
  input  logic                        in_tlast,

  output logic                        out_tvalid,
  input  logic                        out_tready,
  // x_out [31:0], y_out [63:32], heading_out [79:64]
  output logic [wli_pkg::DATA_W-1:0]  out_tdata,
  output logic                        out_tlast,
  // path_end
  output logic                        out_tuser,

  input  logic                        cfg_we,
  input  logic [wli_pkg::PPM_W-1:0]   cfg_wdata
);

  localparam int CW = wli_pkg::COORD_W;
  localparam int HW = wli_pkg::HEAD_W;
  localparam int NW = wli_pkg::N_W;

  wli_pkg::state_t state_r, state_nxt;

  logic [wli_pkg::PPM_W-1:0]    ppm_r;
  logic [CW-1:0]                prev_x_r, prev_y_r, seg_x_r, seg_y_r;
  logic [HW-1:0]                prev_h_r, seg_h_r;
  logic                         have_prev_r, eop_r;
  logic [CW-1:0]                ax_r, ay_r;
  logic                         sx_r, sy_r;
  logic [wli_pkg::IT_W-1:0]     it_r;

  logic [wli_pkg::SQ_OP_W-1:0]  mr_x_r, mr_y_r;
  logic [2*wli_pkg::SQ_OP_W-1:0] md_x_r, md_y_r;
  logic [wli_pkg::SQ_ACC_W-1:0] sq_acc_r, sq_acc_nxt;

  logic [wli_pkg::RAD_W-1:0]    rad_r;
  logic [wli_pkg::RREM_W-1:0]   rrem_r, rrem_nxt;
  logic [wli_pkg::ROOT_W-1:0]   root_r, root_nxt;
  logic [wli_pkg::RREM_W+1:0]   rt_cur, rt_trial;

  logic [wli_pkg::PPM_W-1:0]    mm_r;
  logic [wli_pkg::MUL_W-1:0]    mmd_r, macc_r, macc_nxt;
  logic [wli_pkg::TOP_W-1:0]    len_top;
  logic [NW-1:0]                n_calc, n_r;

  logic [CW-1:0]                dq_x_r, dq_y_r, dq_x_nxt, dq_y_nxt;
  logic [NW-1:0]                dr_x_r, dr_y_r, dr_x_nxt, dr_y_nxt;
  logic [NW:0]                  dt_x, dt_y;

  logic [CW-1:0]                iq_x_r, iq_y_r;
  logic [NW-1:0]                ir_x_r, ir_y_r;
  logic [NW:0]                  is_x, is_y;
  logic                         ic_x, ic_y;
  logic [wli_pkg::J_W-1:0]      j_r;
  logic                         j_done;

  logic [CW:0]                  in_dx, in_dy;
  logic [CW-1:0]                in_ax, in_ay;
  logic                         in_fire, slot_free, load_out;

  logic [CW-1:0]                o_x, o_y, step_x, step_y;
  logic [HW-1:0]                o_h;
  logic                         o_last, o_pend;

  logic                         out_valid_r, out_last_r, out_pend_r;
  logic [CW-1:0]                out_x_r, out_y_r;
  logic [HW-1:0]                out_h_r;

  // input decode
  always_comb begin
    in_dx = {in_tdata[CW-1], in_tdata[CW-1:0]} - {prev_x_r[CW-1], prev_x_r};
    in_dy = {in_tdata[2*CW-1], in_tdata[2*CW-1:CW]} - {prev_y_r[CW-1], prev_y_r};
    in_ax = in_dx[CW] ? CW'(-in_dx) : in_dx[CW-1:0];
    in_ay = in_dy[CW] ? CW'(-in_dy) : in_dy[CW-1:0];
  end

  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // serial units
  always_comb begin
    sq_acc_nxt = sq_acc_r
               + (mr_x_r[0] ? {1'b0, md_x_r} : '0)
               + (mr_y_r[0] ? {1'b0, md_y_r} : '0);

    rt_cur   = {rrem_r, rad_r[wli_pkg::RAD_W-1 -: 2]};
    rt_trial = {2'b00, root_r, 2'b01};
    if (rt_cur >= rt_trial) begin
      rrem_nxt = wli_pkg::RREM_W'(rt_cur - rt_trial);
      root_nxt = {root_r[wli_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      rrem_nxt = wli_pkg::RREM_W'(rt_cur);
      root_nxt = {root_r[wli_pkg::ROOT_W-2:0], 1'b0};
    end

    macc_nxt = macc_r + (mm_r[0] ? mmd_r : '0);
    len_top  = macc_nxt[wli_pkg::MUL_W-1:wli_pkg::FRAC_W];
    n_calc   = (len_top > wli_pkg::TOP_W'(wli_pkg::MAX_STEPS)) ? wli_pkg::N_MAX
                                                               : len_top[NW-1:0];

    dt_x = {dr_x_r, dq_x_r[CW-1]};
    dt_y = {dr_y_r, dq_y_r[CW-1]};
    if (dt_x >= {1'b0, n_r}) begin
      dr_x_nxt = NW'(dt_x - {1'b0, n_r});
      dq_x_nxt = {dq_x_r[CW-2:0], 1'b1};
    end else begin
      dr_x_nxt = dt_x[NW-1:0];
      dq_x_nxt = {dq_x_r[CW-2:0], 1'b0};
    end
    if (dt_y >= {1'b0, n_r}) begin
      dr_y_nxt = NW'(dt_y - {1'b0, n_r});
      dq_y_nxt = {dq_y_r[CW-2:0], 1'b1};
    end else begin
      dr_y_nxt = dt_y[NW-1:0];
      dq_y_nxt = {dq_y_r[CW-2:0], 1'b0};
    end

    is_x = {1'b0, ir_x_r} + {1'b0, dr_x_r};
    is_y = {1'b0, ir_y_r} + {1'b0, dr_y_r};
    ic_x = is_x >= {1'b0, n_r};
    ic_y = is_y >= {1'b0, n_r};

    step_x = sx_r ? seg_x_r - iq_x_r : seg_x_r + iq_x_r;
    step_y = sy_r ? seg_y_r - iq_y_r : seg_y_r + iq_y_r;
    j_done = NW'(j_r) == n_r - wli_pkg::N_MIN;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wli_pkg::S_IDLE: begin
        if (in_fire) begin
          if (have_prev_r) begin
            if (ppm_r == '0) begin
              state_nxt = wli_pkg::S_HEAD;
            end else if (in_ax[CW-1] || in_ay[CW-1]) begin
              state_nxt = wli_pkg::S_DIV;
            end else begin
              state_nxt = wli_pkg::S_SQR;
            end
          end else if (in_tlast) begin
            state_nxt = wli_pkg::S_END;
          end
        end
      end
      wli_pkg::S_SQR: begin
        if (it_r == wli_pkg::SQ_LAST) state_nxt = wli_pkg::S_ROOT;
      end
      wli_pkg::S_ROOT: begin
        if (it_r == wli_pkg::ROOT_LAST) state_nxt = wli_pkg::S_MUL;
      end
      wli_pkg::S_MUL: begin
        if (it_r == wli_pkg::MUL_LAST) begin
          state_nxt = (n_calc >= wli_pkg::N_MIN) ? wli_pkg::S_DIV : wli_pkg::S_HEAD;
        end
      end
      wli_pkg::S_DIV: begin
        if (it_r == wli_pkg::DIV_LAST) state_nxt = wli_pkg::S_HEAD;
      end
      wli_pkg::S_HEAD: begin
        if (slot_free) begin
          if (n_r >= wli_pkg::N_MIN) state_nxt = wli_pkg::S_STEP;
          else if (eop_r)            state_nxt = wli_pkg::S_END;
          else                       state_nxt = wli_pkg::S_IDLE;
        end
      end
      wli_pkg::S_STEP: begin
        if (slot_free && j_done) begin
          state_nxt = eop_r ? wli_pkg::S_END : wli_pkg::S_IDLE;
        end
      end
      wli_pkg::S_END: begin
        if (slot_free) state_nxt = wli_pkg::S_IDLE;
      end
      default: state_nxt = wli_pkg::S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_tready = 1'b0;
    load_out  = 1'b0;
    o_x       = seg_x_r;
    o_y       = seg_y_r;
    o_h       = seg_h_r;
    o_last    = 1'b0;
    o_pend    = 1'b0;
    unique case (state_r)
      wli_pkg::S_IDLE: in_tready = 1'b1;
      wli_pkg::S_HEAD: begin
        load_out = slot_free;
        o_last   = (n_r < wli_pkg::N_MIN) && !eop_r;
      end
      wli_pkg::S_STEP: begin
        load_out = slot_free;
        o_x      = step_x;
        o_y      = step_y;
        o_last   = j_done && !eop_r;
      end
      wli_pkg::S_END: begin
        load_out = slot_free;
        o_x      = prev_x_r;
        o_y      = prev_y_r;
        o_h      = prev_h_r;
        o_last   = 1'b1;
        o_pend   = 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wli_pkg::S_IDLE;
      ppm_r       <= wli_pkg::PPM_RESET;
      have_prev_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_h_r    <= '0;
      out_valid_r <= 1'b0;
      it_r        <= '0;
    end else begin
      state_r <= state_nxt;
      it_r    <= (state_nxt != state_r) ? '0 : it_r + 1'b1;
      if (cfg_we) ppm_r <= cfg_wdata;
      if (in_fire) begin
        have_prev_r <= !in_tlast;
        prev_x_r    <= in_tdata[CW-1:0];
        prev_y_r    <= in_tdata[2*CW-1:CW];
        prev_h_r    <= in_tdata[wli_pkg::DATA_W-1:2*CW];
      end
      if (load_out)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      wli_pkg::S_IDLE: begin
        if (in_fire) begin
          seg_x_r  <= prev_x_r;
          seg_y_r  <= prev_y_r;
          seg_h_r  <= prev_h_r;
          eop_r    <= in_tlast;
          ax_r     <= in_ax;
          ay_r     <= in_ay;
          sx_r     <= in_dx[CW];
          sy_r     <= in_dy[CW];
          mr_x_r   <= in_ax[wli_pkg::SQ_OP_W-1:0];
          mr_y_r   <= in_ay[wli_pkg::SQ_OP_W-1:0];
          md_x_r   <= {{wli_pkg::SQ_OP_W{1'b0}}, in_ax[wli_pkg::SQ_OP_W-1:0]};
          md_y_r   <= {{wli_pkg::SQ_OP_W{1'b0}}, in_ay[wli_pkg::SQ_OP_W-1:0]};
          sq_acc_r <= '0;
          n_r      <= (ppm_r == '0) ? '0 : wli_pkg::N_MAX;
          dq_x_r   <= in_ax;
          dq_y_r   <= in_ay;
          dr_x_r   <= '0;
          dr_y_r   <= '0;
        end
      end
      wli_pkg::S_SQR: begin
        sq_acc_r <= sq_acc_nxt;
        mr_x_r   <= mr_x_r >> 1;
        mr_y_r   <= mr_y_r >> 1;
        md_x_r   <= md_x_r << 1;
        md_y_r   <= md_y_r << 1;
        rad_r    <= {1'b0, sq_acc_nxt};
        rrem_r   <= '0;
        root_r   <= '0;
      end
      wli_pkg::S_ROOT: begin
        rad_r  <= rad_r << 2;
        rrem_r <= rrem_nxt;
        root_r <= root_nxt;
        mm_r   <= ppm_r;
        mmd_r  <= {{wli_pkg::PPM_W{1'b0}}, root_nxt};
        macc_r <= '0;
      end
      wli_pkg::S_MUL: begin
        macc_r <= macc_nxt;
        mm_r   <= mm_r >> 1;
        mmd_r  <= mmd_r << 1;
        n_r    <= n_calc;
        dq_x_r <= ax_r;
        dq_y_r <= ay_r;
        dr_x_r <= '0;
        dr_y_r <= '0;
      end
      wli_pkg::S_DIV: begin
        dq_x_r <= dq_x_nxt;
        dq_y_r <= dq_y_nxt;
        dr_x_r <= dr_x_nxt;
        dr_y_r <= dr_y_nxt;
        iq_x_r <= '0;
        iq_y_r <= '0;
        ir_x_r <= '0;
        ir_y_r <= '0;
        j_r    <= '0;
      end
      wli_pkg::S_STEP: begin
        if (slot_free) begin
          ir_x_r <= ic_x ? NW'(is_x - {1'b0, n_r}) : is_x[NW-1:0];
          ir_y_r <= ic_y ? NW'(is_y - {1'b0, n_r}) : is_y[NW-1:0];
          iq_x_r <= iq_x_r + dq_x_r + CW'(ic_x);
          iq_y_r <= iq_y_r + dq_y_r + CW'(ic_y);
          j_r    <= j_r + 1'b1;
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_x_r    <= o_x;
      out_y_r    <= o_y;
      out_h_r    <= o_h;
      out_last_r <= o_last;
      out_pend_r <= o_pend;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_h_r, out_y_r, out_x_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_pend_r;

  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wli_pkg::S_STEP) |-> (n_r >= wli_pkg::N_MIN && n_r <= wli_pkg::N_MAX))
    else $error("step count out of range while emitting");

  a_step_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wli_pkg::S_STEP) |-> (NW'(j_r) <= n_r - wli_pkg::N_MIN))
    else $error("point index beyond segment");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wli_pkg::S_STEP) |-> (ir_x_r < n_r && ir_y_r < n_r &&
                                      dr_x_r < n_r && dr_y_r < n_r))
    else $error("step remainder not reduced");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("path end item not closing its run");

  a_eop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> !have_prev_r)
    else $error("held point kept after end of path");

endmodule
